// ===== design/quoted_line_tokenizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// quoted line tokenizer assertion macros
// shared assertion shorthands for the tokenizer checker
// ----------------------------------------------------------------------------
`ifndef QUOTED_LINE_TOKENIZER_UNIT_MACROS_SVH
`define QUOTED_LINE_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define QLT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// next-cycle implication, disabled during reset
`define QLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

// ===== design/qlt_pkg.sv =====
// ----------------------------------------------------------------------------
// qlt_pkg
// shared types and constants of the quoted line tokenizer
// ----------------------------------------------------------------------------
package qlt_pkg;

   localparam int TEXT_W  = 8;
   localparam int LINE_W  = 16;
   localparam int COL_W   = 11;
   localparam int MAX_RUN = 4;
   localparam int RUN_IDX_W = $clog2(MAX_RUN);
   localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

   localparam int MAX_COLUMN_DEFAULT = 1024;
   localparam int MAX_LINES_DEFAULT  = 65535;

   // character codes
   localparam logic [TEXT_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [TEXT_W-1:0] CH_HASH    = 8'h23;
   localparam logic [TEXT_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [TEXT_W-1:0] CH_QUOTE   = 8'h22;
   localparam logic [TEXT_W-1:0] CH_BSLASH  = 8'h5C;
   localparam logic [TEXT_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [TEXT_W-1:0] CH_TAB     = 8'h09;
   localparam logic [TEXT_W-1:0] CH_CR      = 8'h0D;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_OK   = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic in_quotes;
      logic escape_next;
      logic in_comment;
      logic slash_held;
      logic token_open;
   } flags_type;

   typedef struct packed {
      kind_type          kind;
      logic [TEXT_W-1:0] tok_byte;
      logic [COL_W-1:0]  err_col;
   } res_type;

   function automatic res_type make_res(input kind_type k, input logic [TEXT_W-1:0] b,
                                        input logic [COL_W-1:0] c);
      res_type r;
      r.kind     = k;
      r.tok_byte = b;
      r.err_col  = c;
      return r;
   endfunction

endpackage

// ===== design/qlt_step.sv =====
// ----------------------------------------------------------------------------
// qlt_step
// next-state and result run for one text byte
// ----------------------------------------------------------------------------
module qlt_step #(
   parameter int MAX_COLUMN = qlt_pkg::MAX_COLUMN_DEFAULT,
   parameter int MAX_LINES  = qlt_pkg::MAX_LINES_DEFAULT,
   localparam int COL_CNT_W  = $clog2(MAX_COLUMN + 1),
   localparam int LINE_CNT_W = $clog2(MAX_LINES + 1)
) (
   input  logic [qlt_pkg::TEXT_W-1:0]    text_byte,
   input  logic                          text_end,
   input  qlt_pkg::flags_type            flags_cur,
   input  logic [COL_CNT_W-1:0]          col_cur,
   input  logic [LINE_CNT_W-1:0]         line_cur,
   output qlt_pkg::flags_type            flags_nxt,
   output logic [COL_CNT_W-1:0]          col_nxt,
   output logic [LINE_CNT_W-1:0]         line_nxt,
   output qlt_pkg::res_type              run [qlt_pkg::MAX_RUN],
   output logic [qlt_pkg::RUN_CNT_W-1:0] run_cnt
);

   localparam logic [COL_CNT_W-1:0]  COL_LIMIT  = COL_CNT_W'(MAX_COLUMN);
   localparam logic [LINE_CNT_W-1:0] LINE_LIMIT = LINE_CNT_W'(MAX_LINES);

   qlt_pkg::flags_type          fl;
   logic [COL_CNT_W-1:0]        col;
   logic [qlt_pkg::RUN_CNT_W-1:0] n;
   logic                        go;
   logic                        do_close;
   logic                        text_done;
   logic                        unquoted;

   function automatic logic [COL_CNT_W-1:0] col_inc(input logic [COL_CNT_W-1:0] c);
      return (c < COL_LIMIT) ? c + 1'b1 : c;
   endfunction

   always_comb begin
      fl        = flags_cur;
      col       = col_cur;
      n         = '0;
      go        = 1'b0;
      do_close  = 1'b0;
      text_done = 1'b0;
      unquoted  = 1'b0;
      for (int i = 0; i < qlt_pkg::MAX_RUN; i++) begin
         run[i] = qlt_pkg::make_res(qlt_pkg::KIND_BYTE, '0, '0);
      end

      if (text_byte == qlt_pkg::CH_NEWLINE) begin
         do_close  = 1'b1;
         text_done = text_end;
      end else begin
         if (!fl.in_comment) begin
            go = 1'b1;
            // held slash resolves against this byte
            if (fl.slash_held) begin
               fl.slash_held = 1'b0;
               if (text_byte == qlt_pkg::CH_SLASH) begin
                  fl.in_comment = 1'b1;
                  go            = 1'b0;
               end else begin
                  run[n[qlt_pkg::RUN_IDX_W-1:0]] =
                     qlt_pkg::make_res(qlt_pkg::KIND_BYTE, qlt_pkg::CH_SLASH, '0);
                  n             = n + 1'b1;
                  fl.token_open = 1'b1;
                  col           = col_inc(col);
               end
            end
            if (go) begin
               unquoted = !fl.in_quotes;
               priority if (fl.escape_next) begin
                  fl.escape_next = 1'b0;
                  run[n[qlt_pkg::RUN_IDX_W-1:0]] =
                     qlt_pkg::make_res(qlt_pkg::KIND_BYTE, text_byte, '0);
                  n             = n + 1'b1;
                  fl.token_open = 1'b1;
                  col           = col_inc(col);
               end else if (fl.in_quotes && text_byte == qlt_pkg::CH_BSLASH) begin
                  fl.escape_next = 1'b1;
                  col            = col_inc(col);
               end else if (text_byte == qlt_pkg::CH_QUOTE) begin
                  fl.in_quotes = !fl.in_quotes;
                  col          = col_inc(col);
               end else if (unquoted && text_byte == qlt_pkg::CH_HASH) begin
                  fl.in_comment = 1'b1;
               end else if (unquoted && text_byte == qlt_pkg::CH_SLASH) begin
                  fl.slash_held = 1'b1;
               end else if (unquoted && (text_byte == qlt_pkg::CH_SPACE ||
                                         text_byte == qlt_pkg::CH_TAB ||
                                         text_byte == qlt_pkg::CH_CR)) begin
                  if (fl.token_open) begin
                     run[n[qlt_pkg::RUN_IDX_W-1:0]] =
                        qlt_pkg::make_res(qlt_pkg::KIND_END, '0, '0);
                     n = n + 1'b1;
                  end
                  fl.token_open = 1'b0;
                  col           = col_inc(col);
               end else begin
                  run[n[qlt_pkg::RUN_IDX_W-1:0]] =
                     qlt_pkg::make_res(qlt_pkg::KIND_BYTE, text_byte, '0);
                  n             = n + 1'b1;
                  fl.token_open = 1'b1;
                  col           = col_inc(col);
               end
            end
         end
         do_close  = text_end;
         text_done = 1'b1;
      end

      line_nxt = line_cur;
      if (do_close) begin
         // a slash still held at line end is a plain token byte
         if (fl.slash_held) begin
            run[n[qlt_pkg::RUN_IDX_W-1:0]] =
               qlt_pkg::make_res(qlt_pkg::KIND_BYTE, qlt_pkg::CH_SLASH, '0);
            n             = n + 1'b1;
            fl.token_open = 1'b1;
            col           = col_inc(col);
         end
         if (fl.in_quotes) begin
            run[n[qlt_pkg::RUN_IDX_W-1:0]] =
               qlt_pkg::make_res(qlt_pkg::KIND_ERR, '0, qlt_pkg::COL_W'(col));
            n = n + 1'b1;
         end else begin
            if (fl.token_open) begin
               run[n[qlt_pkg::RUN_IDX_W-1:0]] =
                  qlt_pkg::make_res(qlt_pkg::KIND_END, '0, '0);
               n = n + 1'b1;
            end
            run[n[qlt_pkg::RUN_IDX_W-1:0]] = qlt_pkg::make_res(qlt_pkg::KIND_OK, '0, '0);
            n = n + 1'b1;
         end
         fl  = '0;
         col = COL_CNT_W'(1);
         if (text_done) begin
            line_nxt = LINE_CNT_W'(1);
         end else if (line_cur < LINE_LIMIT) begin
            line_nxt = line_cur + 1'b1;
         end
      end

      flags_nxt = fl;
      col_nxt   = col;
      run_cnt   = n;
   end

endmodule

// ===== design/quoted_line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// quoted_line_tokenizer_unit
// byte-serial shell-style tokenizer with quotes, escapes and comments
// ----------------------------------------------------------------------------
// One text byte enters per beat on the req_ channel and is held in an input
// register; its whole run of results (zero to four: token bytes, token ends
// and one line-close result) is worked out in one pass and loaded into the
// run register once that register is free; the rsp_ channel drains it one
// result per beat, with rsp_last_of_run set on the final one. While the
// receiver does not stall, plain text that gives zero or one result per byte
// flows at one byte per cycle; a byte that gives several results holds the
// result port until they have all left, the single result port being what
// sets the rate. While a run drains, the next byte waits in the input register
// and the input stalls; that byte moves into the run register, and a new byte
// is taken, in the same cycle that the last result of the run leaves. Line
// numbers and error columns saturate at MAX_LINES and MAX_COLUMN; a byte
// with the end flag closes the line and returns the tokenizer to line one.
// ----------------------------------------------------------------------------
module quoted_line_tokenizer_unit #(
   parameter int MAX_COLUMN = qlt_pkg::MAX_COLUMN_DEFAULT,
   parameter int MAX_LINES  = qlt_pkg::MAX_LINES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // text input channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [qlt_pkg::TEXT_W-1:0] req_text_byte,
   input  logic                       req_text_end,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_result_kind,
   output logic [qlt_pkg::TEXT_W-1:0] rsp_token_byte,
   output logic [qlt_pkg::LINE_W-1:0] rsp_line_number,
   output logic [qlt_pkg::COL_W-1:0]  rsp_error_column,
   output logic                       rsp_last_of_run
);

   localparam int COL_CNT_W  = $clog2(MAX_COLUMN + 1);
   localparam int LINE_CNT_W = $clog2(MAX_LINES + 1);

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic [qlt_pkg::TEXT_W-1:0] in_byte_ff;
   logic                       in_end_ff;

   // tokenizer state
   qlt_pkg::flags_type         flags_ff, flags_in;
   logic [COL_CNT_W-1:0]       col_ff, col_in;
   logic [LINE_CNT_W-1:0]      line_ff, line_in;

   // run register: results of one byte, drained one per beat
   qlt_pkg::res_type           run_ff [qlt_pkg::MAX_RUN];
   qlt_pkg::res_type           run_in [qlt_pkg::MAX_RUN];
   logic [qlt_pkg::RUN_CNT_W-1:0] left_ff, left_in;
   logic [qlt_pkg::RUN_CNT_W-1:0] run_cnt;
   logic [qlt_pkg::RUN_IDX_W-1:0] idx_ff, idx_in;
   logic [qlt_pkg::LINE_W-1:0]    run_line_ff;

   logic req_take;
   logic rsp_take;
   logic run_free;
   logic move;
   qlt_pkg::res_type cur;

   qlt_step #(
      .MAX_COLUMN (MAX_COLUMN),
      .MAX_LINES  (MAX_LINES)
   ) u_step (
      .text_byte (in_byte_ff),
      .text_end  (in_end_ff),
      .flags_cur (flags_ff),
      .col_cur   (col_ff),
      .line_cur  (line_ff),
      .flags_nxt (flags_in),
      .col_nxt   (col_in),
      .line_nxt  (line_in),
      .run       (run_in),
      .run_cnt   (run_cnt)
   );

   // handshakes
   assign rsp_valid = (left_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   // run register can take a new run once its last result leaves
   assign run_free  = (left_ff == '0) ||
                      (left_ff == qlt_pkg::RUN_CNT_W'(1) && rsp_take);
   assign move      = in_valid_ff && run_free;
   assign req_stall = in_valid_ff && !run_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      left_in = left_ff;
      idx_in  = idx_ff;
      if (move) begin
         left_in = run_cnt;
         idx_in  = '0;
      end else if (rsp_take) begin
         left_in = left_ff - 1'b1;
         idx_in  = idx_ff + 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         left_ff     <= '0;
         idx_ff      <= '0;
         flags_ff    <= '0;
         col_ff      <= COL_CNT_W'(1);
         line_ff     <= LINE_CNT_W'(1);
      end else begin
         in_valid_ff <= in_valid_in;
         left_ff     <= left_in;
         idx_ff      <= idx_in;
         if (move) begin
            flags_ff <= flags_in;
            col_ff   <= col_in;
            line_ff  <= line_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
         in_end_ff  <= req_text_end;
      end
      if (move) begin
         run_ff      <= run_in;
         // every result of a byte carries the line it started on
         run_line_ff <= qlt_pkg::LINE_W'(line_ff);
      end
   end

   assign cur              = run_ff[idx_ff];
   assign rsp_result_kind  = cur.kind;
   assign rsp_token_byte   = cur.tok_byte;
   assign rsp_error_column = cur.err_col;
   assign rsp_line_number  = run_line_ff;
   assign rsp_last_of_run  = (left_ff == qlt_pkg::RUN_CNT_W'(1));

endmodule

// ===== design/qlt_checker.sv =====
// ----------------------------------------------------------------------------
// qlt_checker
// port-level checks of the quoted line tokenizer, bound to the top level
// ----------------------------------------------------------------------------
`include "quoted_line_tokenizer_unit_macros.svh"

module qlt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_result_kind,
   input logic [qlt_pkg::TEXT_W-1:0] rsp_token_byte,
   input logic [qlt_pkg::COL_W-1:0]  rsp_error_column,
   input logic                       rsp_last_of_run
);

   logic is_close;

   assign is_close  = (rsp_result_kind == qlt_pkg::KIND_OK) ||
                      (rsp_result_kind == qlt_pkg::KIND_ERR);

   // a stalled result beat holds
   `QLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_token_byte) && $stable(rsp_last_of_run))
   // only token-byte beats carry a character
   `QLT_ASSERT_IMP(a_byte_zero, clock, reset, rsp_valid && rsp_result_kind != qlt_pkg::KIND_BYTE, rsp_token_byte == '0)
   // only error beats carry a column, and it is never zero
   `QLT_ASSERT_IMP(a_col_err, clock, reset, rsp_valid, (rsp_result_kind == qlt_pkg::KIND_ERR) == (rsp_error_column != '0))
   // a line close always ends the run of its byte
   `QLT_ASSERT_IMP(a_close_last, clock, reset, rsp_valid && is_close, rsp_last_of_run)
   // input only stalls behind a pending result
   `QLT_ASSERT_IMP(a_stall_busy, clock, reset, req_stall, rsp_valid)

endmodule

bind quoted_line_tokenizer_unit qlt_checker u_qlt_checker (.*);

// ===== tb/sv/tb_quoted_line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_quoted_line_tokenizer_unit
// self-checking bench for the byte-serial quoted line tokenizer
// ----------------------------------------------------------------------------
// Text bytes go in one beat at a time on the req_ channel. Each accepted byte
// runs through a bench-side tokenizer that tracks quoting, escapes, comments
// and the held slash. It appends that byte's results to a queue. Every rsp_
// beat is checked field by field against the head of the queue. Directed
// lines cover the special cases. A long receiver hold-off fills the block.
// Random lines, mostly well formed with some noise, run under several
// idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_quoted_line_tokenizer_unit;

   localparam int MAX_COLUMN      = qlt_pkg::MAX_COLUMN_DEFAULT;
   localparam int MAX_LINES       = qlt_pkg::MAX_LINES_DEFAULT;
   localparam int RESET_CYCLES    = 10;
   localparam int DRAIN_CYCLES    = 10;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_ITEMS     = 40;

   // one expected result beat
   typedef struct {
      qlt_pkg::kind_type                kind;
      logic [qlt_pkg::TEXT_W-1:0]       text;
      logic [qlt_pkg::LINE_W-1:0]       line_no;
      logic [qlt_pkg::COL_W-1:0]        err_col;
      logic                             last_beat;
   } token_result_type;

   // dut hookup, every input known from time zero
   logic                         clock;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_stall;
   logic [qlt_pkg::TEXT_W-1:0]   req_text_byte = '0;
   logic                         req_text_end  = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall     = 1'b0;
   logic [1:0]                   rsp_result_kind;
   logic [qlt_pkg::TEXT_W-1:0]   rsp_token_byte;
   logic [qlt_pkg::LINE_W-1:0]   rsp_line_number;
   logic [qlt_pkg::COL_W-1:0]    rsp_error_column;
   logic                         rsp_last_of_run;

   // bench bookkeeping
   token_result_type    expected_results[$];
   token_result_type    run_results[$];
   int                  mismatches      = 0;
   int                  items_sent      = 0;
   int                  sender_idle_pct = 0;
   int                  stall_pct       = 0;
   int                  hold_off_len    = 0;
   int                  quiet_cycles    = 0;

   // tokenizer state as the bench sees it, reset values
   logic                         quote_open    = 1'b0;
   logic                         escape_armed  = 1'b0;
   logic                         comment_open  = 1'b0;
   logic                         slash_waiting = 1'b0;
   logic                         token_live    = 1'b0;
   logic [qlt_pkg::COL_W-1:0]    column_no     = qlt_pkg::COL_W'(1);
   logic [qlt_pkg::LINE_W-1:0]   line_no       = qlt_pkg::LINE_W'(1);

   quoted_line_tokenizer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_text_end     (req_text_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_token_byte   (rsp_token_byte),
      .rsp_line_number  (rsp_line_number),
      .rsp_error_column (rsp_error_column),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // bench tokenizer
   // ------------------------------------------------------------------------

   function automatic void add_result(input qlt_pkg::kind_type k,
                                      input logic [qlt_pkg::TEXT_W-1:0] b,
                                      input logic [qlt_pkg::COL_W-1:0] col);
      token_result_type r;
      r.kind      = k;
      r.text      = b;
      r.line_no   = line_no;
      r.err_col   = col;
      r.last_beat = 1'b0;
      run_results.insert(run_results.size(), r);
   endfunction

   // column counter stops at its ceiling
   function automatic void step_column();
      if (column_no < MAX_COLUMN)
         column_no++;
   endfunction

   function automatic void add_token_char(input logic [qlt_pkg::TEXT_W-1:0] c);
      add_result(qlt_pkg::KIND_BYTE, c, '0);
      token_live = 1'b1;
      step_column();
   endfunction

   // one character inside a line
   function automatic void scan_char(input logic [qlt_pkg::TEXT_W-1:0] c);
      if (comment_open)
         return;
      // a held slash either opens a comment or becomes a plain token byte
      if (slash_waiting) begin
         slash_waiting = 1'b0;
         if (c == qlt_pkg::CH_SLASH) begin
            comment_open = 1'b1;
            return;
         end
         add_token_char(qlt_pkg::CH_SLASH);
      end
      if (escape_armed) begin
         escape_armed = 1'b0;
         add_token_char(c);
      end else if (quote_open && c == qlt_pkg::CH_BSLASH) begin
         escape_armed = 1'b1;
         step_column();
      end else if (c == qlt_pkg::CH_QUOTE) begin
         quote_open = ~quote_open;
         step_column();
      end else if (!quote_open && c == qlt_pkg::CH_HASH) begin
         comment_open = 1'b1;
      end else if (!quote_open && c == qlt_pkg::CH_SLASH) begin
         slash_waiting = 1'b1;
      end else if (!quote_open && (c == qlt_pkg::CH_SPACE || c == qlt_pkg::CH_TAB ||
                                   c == qlt_pkg::CH_CR)) begin
         if (token_live)
            add_result(qlt_pkg::KIND_END, '0, '0);
         token_live = 1'b0;
         step_column();
      end else begin
         add_token_char(c);
      end
   endfunction

   // line close: flush the held slash, then ok or unterminated quote
   function automatic void close_text_line(input logic text_done);
      if (slash_waiting) begin
         slash_waiting = 1'b0;
         add_token_char(qlt_pkg::CH_SLASH);
      end
      if (quote_open) begin
         add_result(qlt_pkg::KIND_ERR, '0, column_no);
      end else begin
         if (token_live)
            add_result(qlt_pkg::KIND_END, '0, '0);
         add_result(qlt_pkg::KIND_OK, '0, '0);
      end
      quote_open   = 1'b0;
      escape_armed = 1'b0;
      comment_open = 1'b0;
      token_live   = 1'b0;
      column_no    = qlt_pkg::COL_W'(1);
      if (text_done)
         line_no = qlt_pkg::LINE_W'(1);
      else if (line_no < MAX_LINES)
         line_no++;
   endfunction

   // all results one accepted byte causes, queued in order
   function automatic void tokenize_byte(input logic [qlt_pkg::TEXT_W-1:0] b,
                                         input logic text_end);
      run_results.delete();
      if (b == qlt_pkg::CH_NEWLINE) begin
         close_text_line(text_end);
      end else begin
         scan_char(b);
         if (text_end)
            close_text_line(1'b1);
      end
      if (run_results.size() > 0)
         run_results[run_results.size() - 1].last_beat = 1'b1;
      foreach (run_results[i])
         expected_results.insert(expected_results.size(), run_results[i]);
   endfunction

   // ------------------------------------------------------------------------
   // result side: stall pattern, long hold-off and the checker
   // ------------------------------------------------------------------------

   // stall changes on the falling edge; hold-off wins over random stall
   always @(negedge clock) begin
      rsp_stall <= (hold_off_len > 0) || ($urandom_range(99) < stall_pct);
   end

   // hold-off counted down in cycles, independent of the sender
   always @(posedge clock) begin
      if (hold_off_len > 0)
         hold_off_len <= hold_off_len - 1;
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // every accepted result beat against the oldest expectation
   always @(posedge clock) begin : result_check
      token_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            $error("result beat with nothing expected: kind %0d byte 0x%0h line %0d",
                   rsp_result_kind, rsp_token_byte, rsp_line_number);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("result_kind", 16'(want.kind), 16'(rsp_result_kind));
            check_field("token_byte", 16'(want.text), 16'(rsp_token_byte));
            check_field("line_number", want.line_no, rsp_line_number);
            check_field("error_column", 16'(want.err_col), 16'(rsp_error_column));
            check_field("last_of_run", 16'(want.last_beat), 16'(rsp_last_of_run));
         end
      end
   end

   // watchdog: too long without a beat on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sender helpers
   // ------------------------------------------------------------------------

   // one text byte: optional idle gap, offer, wait for the beat, predict
   task automatic send_text_byte(input logic [qlt_pkg::TEXT_W-1:0] b, input logic text_end);
      int gap;
      gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_text_end  <= text_end;
      do
         @(posedge clock);
      while (req_stall);
      tokenize_byte(b, text_end);
      items_sent++;
      @(negedge clock);
   endtask

   // end flag, if asked, rides on the final character
   task automatic send_string(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++)
         send_text_byte(s[i], end_last && (i == s.len() - 1));
   endtask

   // sender goes quiet until every expected result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // random text
   // ------------------------------------------------------------------------

   // mostly letters, some digits, now and then a lone slash
   function automatic logic [qlt_pkg::TEXT_W-1:0] word_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 85)
         return qlt_pkg::TEXT_W'($urandom_range(97, 122));
      else if (pick < 93)
         return qlt_pkg::TEXT_W'($urandom_range(48, 57));
      else
         return qlt_pkg::CH_SLASH;
   endfunction

   task automatic send_separator();
      case ($urandom_range(2))
         0: send_text_byte(qlt_pkg::CH_SPACE, 1'b0);
         1: send_text_byte(qlt_pkg::CH_TAB, 1'b0);
         default: send_text_byte(qlt_pkg::CH_CR, 1'b0);
      endcase
   endtask

   // plain word, quoted string, or quoted string glued to a word
   task automatic send_random_token();
      int pick;
      int r;
      pick = $urandom_range(99);
      if (pick >= 50) begin
         send_text_byte(qlt_pkg::CH_QUOTE, 1'b0);
         repeat ($urandom_range(0, 5)) begin
            r = $urandom_range(99);
            if (r < 70) begin
               send_text_byte(word_char(), 1'b0);
            end else if (r < 80) begin
               send_text_byte(qlt_pkg::CH_SPACE, 1'b0);
            end else if (r < 88) begin
               send_text_byte(qlt_pkg::CH_HASH, 1'b0);
            end else begin
               // escape followed by any byte at all
               send_text_byte(qlt_pkg::CH_BSLASH, 1'b0);
               send_text_byte(qlt_pkg::TEXT_W'($urandom_range(0, 255)), 1'b0);
            end
         end
         send_text_byte(qlt_pkg::CH_QUOTE, 1'b0);
      end
      if (pick < 50 || pick >= 85)
         repeat ($urandom_range(1, 6)) send_text_byte(word_char(), 1'b0);
   endtask

   // one line: noise, or separated tokens with maybe an open quote or comment
   task automatic send_random_line();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         repeat ($urandom_range(1, 10))
            send_text_byte(qlt_pkg::TEXT_W'($urandom_range(0, 255)), 1'b0);
      end else begin
         if ($urandom_range(3) == 0)
            send_separator();
         for (int t = 0; t < $urandom_range(0, 4); t++) begin
            if (t > 0)
               repeat ($urandom_range(1, 2)) send_separator();
            send_random_token();
         end
         pick = $urandom_range(99);
         if (pick < 10) begin
            // quote left open: the line must end in an error
            send_text_byte(qlt_pkg::CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 3)) send_text_byte(word_char(), 1'b0);
            if ($urandom_range(1) == 0)
               send_text_byte(qlt_pkg::CH_BSLASH, 1'b0);
         end else if (pick < 25) begin
            if ($urandom_range(1) == 0) begin
               send_text_byte(qlt_pkg::CH_HASH, 1'b0);
            end else begin
               send_text_byte(qlt_pkg::CH_SLASH, 1'b0);
               send_text_byte(qlt_pkg::CH_SLASH, 1'b0);
            end
            repeat ($urandom_range(0, 4))
               send_text_byte(qlt_pkg::TEXT_W'($urandom_range(0, 255)), 1'b0);
         end
      end
      // line end: newline, newline closing the text, or end flag on a char
      pick = $urandom_range(99);
      if (pick < 85)
         send_text_byte(qlt_pkg::CH_NEWLINE, 1'b0);
      else if (pick < 92)
         send_text_byte(qlt_pkg::CH_NEWLINE, 1'b1);
      else
         send_text_byte(word_char(), 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // byte extremes, tab and carriage return separators, a token end, empty line
   task automatic test_plain_tokens();
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte(qlt_pkg::CH_TAB, 1'b0);
      send_text_byte(qlt_pkg::CH_CR, 1'b0);
      send_text_byte(qlt_pkg::CH_NEWLINE, 1'b0);
      send_text_byte(qlt_pkg::CH_NEWLINE, 1'b0);
   endtask

   // quoted space kept, escaped quote kept, quotes dropped
   task automatic test_quotes_and_escapes();
      send_string("\"x \\\"y\"z\n", 1'b0);
   endtask

   // slash then letter, double slash comment, hash hides a quote,
   // lone slash closing the text
   task automatic test_comments_and_slash();
      send_string("/a//b\n", 1'b0);
      send_string("#\"\n", 1'b0);
      send_text_byte(qlt_pkg::CH_SLASH, 1'b1);
   endtask

   // trailing backslash inside quotes, newline with the end flag
   task automatic test_quote_errors();
      send_string("\"q\\\n", 1'b1);
   endtask

   // receiver holds off while the sender keeps offering: block fills up
   task automatic test_backpressure();
      wait_for_results();
      sender_idle_pct = 0;
      stall_pct      <= 0;
      hold_off_len   <= HOLD_OFF_CYCLES;
      repeat (4) send_string("tok \"q r\" ", 1'b0);
      send_text_byte(qlt_pkg::CH_NEWLINE, 1'b0);
      wait_for_results();
   endtask

   // random lines under each idle/stall mix
   task automatic test_random_text();
      int idle_mix[4]  = '{0, 60, 0, 16};
      int stall_mix[4] = '{0, 0, 60, 16};
      int target;
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = idle_mix[p];
         stall_pct      <= stall_mix[p];
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target)
            send_random_line();
      end
      wait_for_results();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset          <= 1'b0;
      sender_idle_pct = 16;
      stall_pct      <= 16;
      test_plain_tokens();
      test_quotes_and_escapes();
      test_comments_and_slash();
      test_quote_errors();
      test_backpressure();
      test_random_text();
      wait_for_results();
      if (mismatches == 0 && expected_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
